[sv/chp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chp_pkg
// Shared widths and codes for the chain path counter.
// ----------------------------------------------------------------------------
package chp_pkg;

	localparam int FUNC_W  = 2;
	localparam int NODE_W  = 12;
	localparam int HOP_W   = 5;
	localparam int TOTAL_W = 63;
	localparam int MAX_HOPS = 16;

	localparam logic [FUNC_W-1:0] FUNC_EDGE    = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_END_HOP = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_RESTART = 2'd2;

	// tag of an entry that holds no count of any hop
	localparam logic [HOP_W-1:0] TAG_NONE = '1;

	localparam logic [HOP_W-1:0] NUM_HOPS_RESET = 5'd1;

endpackage
`default_nettype wire

[sv/chp_bank.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chp_bank
// Count bank: synchronous RAM, one read and one write port, registered read
// data, read-first when both ports hit the same entry.
// ----------------------------------------------------------------------------
module chp_bank #(
	parameter int AW = 12,
	parameter int DW = 68
) (
	input  wire logic          clk,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[sv/chain_path_counter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// chain_path_counter
// Counts paths of num_hops hops through a graph streamed as edge transactions.
//
// Input channel (in_valid/in_ready): func selects edge, end of hop or restart;
// src_node/dst_node give the edge. Output channel (out_valid/out_ready): one
// transaction per input transaction with the running total, the hop being
// accumulated and the finished flag, in input order.
// Counts live in two RAM banks that swap roles every hop; each entry carries
// the hop that wrote it, so a stale entry reads as zero and no copy or clear
// is needed at end of hop.
// Result registered in stage 1 (bank read) and the output register; one
// transaction per cycle unless a stalled receiver or a clearing pass holds
// it. A read-modify-write of the same node on back-to-back edges is forwarded.
// Reset and restart: a clearing pass sweeps every entry of both banks, with
// in_ready low meanwhile. cfg_we writes num_hops at any cycle.
// Receiver stall: the pipeline holds, in_ready drops once the result
// register and the stage behind it are full.
// ----------------------------------------------------------------------------
module chain_path_counter #(
	parameter int NODE_COUNT  = 4096,
	parameter int COUNT_WIDTH = 64
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [chp_pkg::HOP_W-1:0]    cfg_wdata,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [chp_pkg::FUNC_W-1:0]   func,
	input  wire logic [chp_pkg::NODE_W-1:0]   src_node,
	input  wire logic [chp_pkg::NODE_W-1:0]   dst_node,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic      [chp_pkg::TOTAL_W-1:0]  total_count,
	output logic      [chp_pkg::HOP_W-1:0]    hop_position,
	output logic                              finished
);

	import chp_pkg::*;

	localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
	localparam int XW = ((AW > NODE_W) ? AW : NODE_W) + 1;
	localparam int VW = COUNT_WIDTH - 1;
	localparam int DW = HOP_W + VW;
	localparam logic [VW-1:0] COUNT_MAX = '1;
	localparam logic [AW-1:0] CLR_LAST = AW'(NODE_COUNT - 1);

	logic [HOP_W-1:0] num_hops_q;
	logic [HOP_W-1:0] hop_q;
	logic             done_q;
	logic             clr_q;
	logic [AW-1:0]    clr_cnt_q;

	logic             acc;
	logic             adv;
	logic [XW-1:0]    src_x;
	logic [XW-1:0]    dst_x;
	logic [AW-1:0]    src_addr;
	logic [AW-1:0]    dst_addr;
	logic             in_range;
	logic [HOP_W-1:0] eff_hops;
	logic             last;

	logic             s1_valid_q;
	logic             edge_s1;
	logic             restart_s1;
	logic             last_s1;
	logic [HOP_W-1:0] hop_s1;
	logic [HOP_W-1:0] hop_out_s1;
	logic             done_out_s1;
	logic [AW-1:0]    dst_addr_s1;

	logic             wr_valid_q;
	logic [AW-1:0]    wr_addr_q;
	logic [VW-1:0]    wr_data_q;

	logic [DW-1:0]    rd0;
	logic [DW-1:0]    rd1;
	logic [DW-1:0]    cur_raw;
	logic [DW-1:0]    nxt_raw;
	logic [VW-1:0]    cur_val;
	logic [VW-1:0]    nxt_val;
	logic [VW-1:0]    add_a;
	logic [VW:0]      sum;
	logic [VW-1:0]    sum_sat;
	logic             wr_s1;
	logic [VW-1:0]    total_q;
	logic [VW-1:0]    total_d;

	logic             b0_wr_en;
	logic             b1_wr_en;
	logic [AW-1:0]    b_wr_addr;
	logic [DW-1:0]    b_wr_data;
	logic [AW-1:0]    b0_rd_addr;
	logic [AW-1:0]    b1_rd_addr;

	assign adv      = s1_valid_q && (!out_valid || out_ready);
	assign in_ready = !clr_q && (!s1_valid_q || adv);
	assign acc      = in_valid && in_ready;

	assign src_x    = XW'(src_node);
	assign dst_x    = XW'(dst_node);
	assign src_addr = src_x[AW-1:0];
	assign dst_addr = dst_x[AW-1:0];
	assign in_range = (src_x < XW'(NODE_COUNT)) && (dst_x < XW'(NODE_COUNT));

	always_comb begin
		if (num_hops_q == '0) begin
			eff_hops = HOP_W'(1);
		end else if (num_hops_q > HOP_W'(MAX_HOPS)) begin
			eff_hops = HOP_W'(MAX_HOPS);
		end else begin
			eff_hops = num_hops_q;
		end
	end

	assign last = ({1'b0, hop_q} + 6'd1) >= {1'b0, eff_hops};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_hops_q <= NUM_HOPS_RESET;
		end else if (cfg_we) begin
			num_hops_q <= cfg_wdata;
		end
	end

	// hop and finished flag advance at acceptance
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hop_q  <= '0;
			done_q <= 1'b0;
		end else if (acc) begin
			case (func)
				FUNC_RESTART: begin
					hop_q  <= '0;
					done_q <= 1'b0;
				end
				FUNC_END_HOP: begin
					if (!done_q) begin
						hop_q <= hop_q + HOP_W'(1);
						if (last) begin
							done_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (acc && func == FUNC_RESTART) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			if (clr_cnt_q == CLR_LAST) begin
				clr_q <= 1'b0;
			end else begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (acc) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			edge_s1     <= (func == FUNC_EDGE) && !done_q && in_range;
			restart_s1  <= (func == FUNC_RESTART);
			last_s1     <= last;
			hop_s1      <= hop_q;
			dst_addr_s1 <= dst_addr;
			if (func == FUNC_RESTART) begin
				hop_out_s1  <= '0;
				done_out_s1 <= 1'b0;
			end else if (func == FUNC_END_HOP && !done_q) begin
				hop_out_s1  <= hop_q + HOP_W'(1);
				done_out_s1 <= last;
			end else begin
				hop_out_s1  <= hop_q;
				done_out_s1 <= done_q;
			end
		end
	end

	// bank 0 holds the current counts on even hops
	assign b0_rd_addr = hop_q[0] ? dst_addr : src_addr;
	assign b1_rd_addr = hop_q[0] ? src_addr : dst_addr;

	chp_bank #(
		.AW(AW),
		.DW(DW)
	) u_bank0 (
		.clk    (clk),
		.rd_en  (acc),
		.rd_addr(b0_rd_addr),
		.rd_data(rd0),
		.wr_en  (b0_wr_en),
		.wr_addr(b_wr_addr),
		.wr_data(b_wr_data)
	);

	chp_bank #(
		.AW(AW),
		.DW(DW)
	) u_bank1 (
		.clk    (clk),
		.rd_en  (acc),
		.rd_addr(b1_rd_addr),
		.rd_data(rd1),
		.wr_en  (b1_wr_en),
		.wr_addr(b_wr_addr),
		.wr_data(b_wr_data)
	);

	assign cur_raw = hop_s1[0] ? rd1 : rd0;
	assign nxt_raw = hop_s1[0] ? rd0 : rd1;

	always_comb begin
		if (hop_s1 == '0) begin
			cur_val = VW'(1);
		end else if (cur_raw[DW-1:VW] == hop_s1 - HOP_W'(1)) begin
			cur_val = cur_raw[VW-1:0];
		end else begin
			cur_val = '0;
		end
		if (wr_valid_q && wr_addr_q == dst_addr_s1) begin
			nxt_val = wr_data_q;
		end else if (nxt_raw[DW-1:VW] == hop_s1) begin
			nxt_val = nxt_raw[VW-1:0];
		end else begin
			nxt_val = '0;
		end
	end

	assign add_a   = last_s1 ? total_q : nxt_val;
	assign sum     = {1'b0, add_a} + {1'b0, cur_val};
	assign sum_sat = (sum >= {1'b0, COUNT_MAX}) ? COUNT_MAX : sum[VW-1:0];
	assign wr_s1   = edge_s1 && !last_s1;

	always_comb begin
		if (restart_s1) begin
			total_d = '0;
		end else if (edge_s1 && last_s1) begin
			total_d = sum_sat;
		end else begin
			total_d = total_q;
		end
	end

	assign b_wr_addr = clr_q ? clr_cnt_q : dst_addr_s1;
	assign b_wr_data = clr_q ? {TAG_NONE, VW'(0)} : {hop_s1, sum_sat};
	assign b0_wr_en  = clr_q || (adv && wr_s1 && hop_s1[0]);
	assign b1_wr_en  = clr_q || (adv && wr_s1 && !hop_s1[0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
			total_q    <= '0;
		end else if (adv) begin
			wr_valid_q <= wr_s1;
			total_q    <= total_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			wr_addr_q <= dst_addr_s1;
			wr_data_q <= sum_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (adv) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			total_count  <= TOTAL_W'(total_d);
			hop_position <= hop_out_s1;
			finished     <= done_out_s1;
		end
	end

endmodule
`default_nettype wire
